// File: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define FAT12_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define FAT12_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/fat12_pkg.sv
// types, codes and helpers for the fat12 allocation table engine
package fat12_pkg;

  // request commands
  typedef enum logic [2:0] {
    CMD_WR_BYTE     = 3'd0,
    CMD_RD_BYTE     = 3'd1,
    CMD_GET_ENTRY   = 3'd2,
    CMD_SET_ENTRY   = 3'd3,
    CMD_COUNT_CHAIN = 3'd4,
    CMD_FREE_CHAIN  = 3'd5
  } cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DATA
  } state_t;

  // first link value that ends a chain (reserved, bad and end markers)
  localparam logic [11:0] LINK_END = 12'hff0;

  // a link that points at another cluster of the chain
  function automatic logic in_chain(input logic [11:0] c);
    return (c != 12'h000) && (c < LINK_END);
  endfunction

endpackage

// File: design/fat12_ram.sv
// generic single-write, single-read ram with registered read data
module fat12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/fat12_table_engine.sv
// fat12 allocation table engine: byte image store with entry and chain commands
//
// A request is taken when start is high and busy is low; its single result is
// shown on read_value, chain_count and status for the one cycle that done is
// high, the first cycle busy is low, and cannot be held off. A new request may
// be given in that same cycle. The table image sits in two byte-wide rams, even
// bytes in one and odd bytes in the other, so both bytes of an entry come out
// of one read. Each ram has a registered read: a byte write ends in the issue
// state; a byte read, get entry or set entry reads in the issue state and
// ends in the data state, where set entry writes back the merged word; a
// chain count or chain free has an issue and a data state per link read,
// plus a last issue state when the walk stops at the ENTRIES bound; a walk
// reads at most ENTRIES links. A chain count from cluster zero, a free that
// starts outside a chain and the unused commands end in the issue state.
// The image holds whatever was last written; unwritten bytes read as unknown.
module fat12_table_engine import fat12_pkg::*; #(
  parameter int ENTRIES     = 4096,
  parameter int IMAGE_BYTES = 6144
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [12:0] byte_offset,
  input  logic [7:0]  byte_data,
  input  logic [11:0] cluster,
  input  logic [11:0] entry_value,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [11:0] read_value,
  output logic [12:0] chain_count,
  output logic        status
);

  localparam int DEPTH0 = (IMAGE_BYTES + 1) / 2;
  localparam int DEPTH1 = IMAGE_BYTES / 2;
  localparam int RW0    = $clog2(DEPTH0);
  localparam int RW1    = $clog2(DEPTH1);
  localparam logic [13:0] IMG_LIMIT   = 14'(IMAGE_BYTES);
  localparam logic [12:0] ENTRY_LIMIT = 13'(ENTRIES);

  state_t      state, state_next;
  cmd_t        cmd;
  logic [12:0] offset;
  logic [7:0]  wdat;
  logic [11:0] cur, cur_next;
  logic [11:0] ev;
  logic [12:0] cnt, cnt_next;
  logic [7:0]  root_dir_sectors;

  // address decode
  logic [13:0] at;
  logic [12:0] row0, row1;
  logic [13:0] idx0, idx1;
  logic        v0, v1;

  // ram side
  logic        we0, we1;
  logic [7:0]  wd0, wd1, d0, d1;

  // entry datapath
  logic [7:0]  b0, b1, lo, hi;
  logic [15:0] w, wn;
  logic [11:0] link, newv;

  // control
  logic        issue_stop, data_more, finish;
  logic [11:0] res_rv;
  logic [12:0] res_cnt;
  logic        res_st;

  // low byte address of the entry or the byte request
  always_comb begin
    if (cmd == CMD_WR_BYTE || cmd == CMD_RD_BYTE) begin
      at = {1'b0, offset};
    end else begin
      at = 14'(cur) + 14'(cur[11:1]);
    end
    row1 = at[13:1];
    row0 = at[13:1] + 13'(at[0]);
    idx0 = {row0, 1'b0};
    idx1 = {row1, 1'b1};
    v0   = idx0 < IMG_LIMIT;
    v1   = idx1 < IMG_LIMIT;
  end

  // even byte bank
  fat12_ram #(.WIDTH(8), .DEPTH(DEPTH0)) u_ram_even (
    .clk   (clk),
    .we    (we0),
    .waddr (row0[RW0-1:0]),
    .wdata (wd0),
    .raddr (row0[RW0-1:0]),
    .rdata (d0)
  );

  // odd byte bank
  fat12_ram #(.WIDTH(8), .DEPTH(DEPTH1)) u_ram_odd (
    .clk   (clk),
    .we    (we1),
    .waddr (row1[RW1-1:0]),
    .wdata (wd1),
    .raddr (row1[RW1-1:0]),
    .rdata (d1)
  );

  // assemble the 16-bit word, pick the link and merge a new value
  always_comb begin
    b0   = v0 ? d0 : 8'h00;
    b1   = v1 ? d1 : 8'h00;
    lo   = at[0] ? b1 : b0;
    hi   = at[0] ? b0 : b1;
    w    = {hi, lo};
    link = cur[0] ? w[15:4] : w[11:0];
    newv = (cmd == CMD_SET_ENTRY) ? ev : 12'h000;
    wn   = cur[0] ? {newv, w[3:0]} : {w[15:12], newv};
  end

  // issue cycle finishes without a read
  always_comb begin
    case (cmd)
      CMD_WR_BYTE:     issue_stop = 1'b1;
      CMD_RD_BYTE:     issue_stop = 1'b0;
      CMD_GET_ENTRY:   issue_stop = 1'b0;
      CMD_SET_ENTRY:   issue_stop = 1'b0;
      CMD_COUNT_CHAIN: issue_stop = (cur == 12'h000) || (cnt >= ENTRY_LIMIT);
      CMD_FREE_CHAIN:  issue_stop = !in_chain(cur) || (cnt >= ENTRY_LIMIT);
      default:         issue_stop = 1'b1;
    endcase
  end

  // chain walks carry on while the link stays in the chain
  assign data_more = (cmd == CMD_COUNT_CHAIN || cmd == CMD_FREE_CHAIN) && in_chain(link);
  assign finish    = (state == ST_ISSUE && issue_stop) || (state == ST_DATA && !data_more);
  assign busy      = (state != ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_next = issue_stop ? ST_IDLE : ST_DATA;
      end
      ST_DATA: begin
        state_next = data_more ? ST_ISSUE : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ram writes, walk registers and result values
  always_comb begin
    we0      = 1'b0;
    we1      = 1'b0;
    wd0      = at[0] ? wn[15:8] : wn[7:0];
    wd1      = at[0] ? wn[7:0] : wn[15:8];
    cur_next = cur;
    cnt_next = cnt;
    res_rv   = 12'h000;
    res_cnt  = 13'h0000;
    res_st   = 1'b0;
    case (state)
      ST_ISSUE: begin
        case (cmd)
          CMD_WR_BYTE: begin
            wd0 = wdat;
            wd1 = wdat;
            we0 = !at[0] && v0;
            we1 = at[0] && v1;
          end
          CMD_COUNT_CHAIN: begin
            if (cur == 12'h000) begin
              res_cnt = 13'(root_dir_sectors);
            end else begin
              res_cnt = ENTRY_LIMIT;
              res_st  = 1'b1;
            end
          end
          CMD_FREE_CHAIN: begin
            res_cnt = cnt;
            res_st  = in_chain(cur);
          end
          default: begin
          end
        endcase
      end
      ST_DATA: begin
        case (cmd)
          CMD_RD_BYTE:   res_rv = 12'(lo);
          CMD_GET_ENTRY: res_rv = link;
          CMD_SET_ENTRY: begin
            we0 = v0;
            we1 = v1;
          end
          CMD_COUNT_CHAIN: begin
            cnt_next = cnt + 13'd1;
            cur_next = link;
            res_cnt  = (link == 12'h000) ? cnt - 13'd1 : cnt;
          end
          CMD_FREE_CHAIN: begin
            we0      = v0;
            we1      = v1;
            cnt_next = cnt + 13'd1;
            cur_next = link;
            res_cnt  = cnt + 13'd1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      done             <= 1'b0;
      root_dir_sectors <= 8'd14;
    end else begin
      state <= state_next;
      done  <= finish;
      if (cfg_write) begin
        root_dir_sectors <= cfg_data;
      end
    end
  end

  // request and walk payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (start) begin
        cmd    <= cmd_t'(command);
        offset <= byte_offset;
        wdat   <= byte_data;
        cur    <= cluster;
        ev     <= entry_value;
        cnt    <= (command == CMD_FREE_CHAIN) ? 13'd0 : 13'd1;
      end
    end else begin
      cur <= cur_next;
      cnt <= cnt_next;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (finish) begin
      read_value  <= res_rv;
      chain_count <= res_cnt;
      status      <= res_st;
    end
  end

endmodule

// File: design/fat12_checker.sv
// port-level checks on the fat12 table engine, bound to the table engine module
`include "assert_macros.svh"

module fat12_checker import fat12_pkg::*; #(
  parameter int ENTRIES = 4096
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [2:0]  command,
  input logic        done,
  input logic [11:0] read_value,
  input logic [12:0] chain_count,
  input logic        status
);

  localparam logic [12:0] ENTRY_LIMIT = 13'(ENTRIES);

  // reset leaves the engine idle with no result showing
  `FAT12_ASSERT_ALWAYS(a_reset_idle, rst |=> !busy && !done, "engine not idle after reset")

  // a result comes out exactly when a request finishes
  `FAT12_ASSERT(a_done_after_busy, done |-> $past(busy), "result without a request in flight")
  `FAT12_ASSERT(a_busy_ends_done, $fell(busy) && !$past(rst) |-> done, "request ended with no result")

  // single-read requests finish in a fixed time
  `FAT12_ASSERT(a_read_latency, start && !busy && (command == CMD_RD_BYTE || command == CMD_GET_ENTRY) |=> ##2 done, "read request latency wrong")

  // a stopped walk reports the bound and no read value
  `FAT12_ASSERT(a_loop_result, done && status |-> chain_count == ENTRY_LIMIT && read_value == 12'h000, "loop stop result wrong")

endmodule

bind fat12_table_engine fat12_checker #(.ENTRIES(ENTRIES)) u_fat12_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .command     (command),
  .done        (done),
  .read_value  (read_value),
  .chain_count (chain_count),
  .status      (status)
);
